[rtl/core/assert_macros.svh]
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/lts_pkg.sv]
`default_nettype none
package lts_pkg;

  localparam int SLOTS_DEF = 16;

  localparam int TKT_W     = 8;
  localparam int ARR_W     = 16;
  localparam int REM_W     = 16;
  localparam int PRIO_W    = 2;
  localparam int TIME_W    = 32;
  localparam int RAND_W    = 31;
  localparam int ID_W      = 5;
  localparam int SLOT_IN_W = 4;
  localparam int CFG_IDX_W = 2;
  localparam int ENT_W     = ARR_W + PRIO_W + REM_W;
  localparam int TKT_MAX   = (1 << TKT_W) - 1;

  localparam logic [TKT_W-1:0] TKT1_RST = TKT_W'(15);
  localparam logic [TKT_W-1:0] TKT2_RST = TKT_W'(10);
  localparam logic [TKT_W-1:0] TKT3_RST = TKT_W'(5);

  localparam logic [CFG_IDX_W-1:0] CFG_TKT1 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TKT2 = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TKT3 = CFG_IDX_W'(2);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [PRIO_W-1:0] PRIO_ONE   = PRIO_W'(1);
  localparam logic [PRIO_W-1:0] PRIO_TWO   = PRIO_W'(2);
  localparam logic [PRIO_W-1:0] PRIO_THREE = PRIO_W'(3);

  typedef struct packed {
    logic [ARR_W-1:0]  arrival;
    logic [PRIO_W-1:0] prio;
    logic [REM_W-1:0]  remaining;
  } lts_entry_t;

  function automatic logic [TKT_W-1:0] tickets_of(
    input logic [PRIO_W-1:0] p,
    input logic [TKT_W-1:0]  t1,
    input logic [TKT_W-1:0]  t2,
    input logic [TKT_W-1:0]  t3
  );
    logic [TKT_W-1:0] t;
    unique case (p)
      PRIO_ONE:   t = t1;
      PRIO_TWO:   t = t2;
      PRIO_THREE: t = t3;
      default:    t = '0;
    endcase
    return t;
  endfunction

endpackage
`default_nettype wire

[rtl/core/lts_ram.sv]
`default_nettype none
module lts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[rtl/core/lts_mod.sv]
`default_nettype none
`include "assert_macros.svh"
module lts_mod #(
  parameter int SUM_W = 12
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lts_pkg::RAND_W-1:0] dividend,
  input  wire logic [SUM_W-1:0]          divisor,
  output logic                           done,
  output logic      [SUM_W-1:0]          remainder
);
  import lts_pkg::*;

  localparam int CNT_W = $clog2(RAND_W + 1);

  logic             running;
  logic [CNT_W-1:0] count;
  logic [RAND_W-1:0] dvd;
  logic [SUM_W-1:0] dvs;
  logic [SUM_W:0]   shifted;
  logic [SUM_W:0]   diff;
  logic             ge;

  assign shifted = {remainder, dvd[RAND_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign ge      = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        count   <= CNT_W'(RAND_W);
      end else if (running) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (running) begin
      dvd       <= dvd << 1;
      remainder <= ge ? diff[SUM_W-1:0] : shifted[SUM_W-1:0];
    end
  end

  `ASSERT_IMPLIES(a_no_restart, clk, rst, start, !running)
  `ASSERT_NEXT(a_start_runs, clk, rst, start, running && !done)
  `ASSERT_IMPLIES(a_rem_range, clk, rst, done, remainder < dvs)

endmodule
`default_nettype wire

[rtl/core/lottery_tick_scheduler.sv]
// Load transaction: accepted in the idle state, result registered from the done state.
// Tick transaction: up to two passes over the slot memory read port (ticket sum,
// then draw walk) and the 31-step bit-serial modulo.
// One transaction in flight; the next is accepted while a result waits.
// Reset: all slots empty (per-slot busy flags cleared at once), time zero,
// tickets 15/10/5; no memory clearing pass.
`default_nettype none
`include "assert_macros.svh"
module lottery_tick_scheduler #(
  parameter int SLOTS = lts_pkg::SLOTS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire logic                         kind,
  input  wire logic [lts_pkg::SLOT_IN_W-1:0] slot,
  input  wire logic [lts_pkg::ARR_W-1:0]     arrival,
  input  wire logic [lts_pkg::REM_W-1:0]     work_units,
  input  wire logic [lts_pkg::PRIO_W-1:0]    prio,
  input  wire logic [lts_pkg::RAND_W-1:0]    random_value,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output logic      [lts_pkg::ID_W-1:0]      granted_id,
  output logic                              finished,
  output logic      [lts_pkg::TIME_W-1:0]    finish_time,
  output logic                              all_done,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lts_pkg::TKT_W-1:0]     cfg_data
);
  import lts_pkg::*;

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SUM_W = $clog2(SLOTS * TKT_MAX + 1);
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SUM  = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]        state;
  logic [TKT_W-1:0]  tkt1, tkt2, tkt3;
  logic [TIME_W-1:0] now;
  logic [SLOTS-1:0]  busy;

  logic              issue_on;
  logic [SW-1:0]     issue_idx;
  logic              rd_vld;
  logic [SW-1:0]     rd_idx;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [SUM_W-1:0]  draw;
  logic [RAND_W-1:0] rand_q;
  logic [ID_W-1:0]   grant_q;
  logic              fin_q;

  logic              ram_we;
  logic [SW-1:0]     ram_waddr;
  lts_entry_t        wr_ent;
  logic [ENT_W-1:0]  ram_rdata;
  lts_entry_t        rd_ent;

  logic              accept;
  logic              load_hit;
  logic              elig;
  logic [TKT_W-1:0]  tk;
  logic              hit;
  logic              sum_last;
  logic              mod_start;
  logic              mod_done;
  logic [SUM_W-1:0]  mod_rem;
  logic              walk_last;
  logic              busy_hold;

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = item_valid && !item_stall;
  assign load_hit   = accept && (kind == KIND_LOAD) && (32'(slot) < 32'(SLOTS));

  assign rd_ent   = lts_entry_t'(ram_rdata);
  assign elig     = busy[rd_idx] && (TIME_W'(rd_ent.arrival) <= now);
  assign tk       = elig ? tickets_of(rd_ent.prio, tkt1, tkt2, tkt3) : '0;
  assign hit      = elig && (draw <= SUM_W'(tk));
  assign sum_next = sum + SUM_W'(tk);
  assign sum_last = (state == S_SUM) && rd_vld && (rd_idx == LAST);
  assign mod_start = sum_last && (sum_next != '0);

  assign walk_last = (state == S_WALK) && rd_vld && (rd_idx == LAST);
  assign busy_hold = (state != S_IDLE) && (state != S_WALK);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SW'(slot);
    wr_ent    = '{arrival: arrival, prio: prio, remaining: work_units};
    if (load_hit) begin
      ram_we = 1'b1;
    end else if ((state == S_WALK) && rd_vld && hit) begin
      ram_we    = 1'b1;
      ram_waddr = rd_idx;
      wr_ent    = '{arrival: rd_ent.arrival, prio: rd_ent.prio,
                    remaining: rd_ent.remaining - REM_W'(1)};
    end
  end

  lts_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_ent),
    .raddr(issue_idx),
    .rdata(ram_rdata)
  );

  lts_mod #(
    .SUM_W(SUM_W)
  ) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (rand_q),
    .divisor  (sum_next),
    .done     (mod_done),
    .remainder(mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tkt1 <= TKT1_RST;
      tkt2 <= TKT2_RST;
      tkt3 <= TKT3_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TKT1: tkt1 <= cfg_data;
        CFG_TKT2: tkt2 <= cfg_data;
        CFG_TKT3: tkt3 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on <= 1'b0;
      rd_vld   <= 1'b0;
    end else begin
      rd_vld <= issue_on;
      if ((accept && (kind == KIND_TICK) && (busy != '0)) ||
          ((state == S_MOD) && mod_done)) begin
        issue_on  <= 1'b1;
        issue_idx <= '0;
      end else if (issue_on) begin
        issue_idx <= issue_idx + SW'(1);
        if ((issue_idx == LAST) || ((state == S_WALK) && rd_vld && hit)) begin
          issue_on <= 1'b0;
        end
      end
    end
    rd_idx <= issue_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      now          <= '0;
      busy         <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            grant_q <= '0;
            fin_q   <= 1'b0;
            rand_q  <= random_value;
            sum     <= '0;
            if (load_hit) begin
              busy[SW'(slot)] <= (work_units != '0);
            end
            if ((kind == KIND_TICK) && (busy != '0)) begin
              state <= S_SUM;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SUM: begin
          if (rd_vld) begin
            sum <= sum_next;
          end
          if (sum_last) begin
            if (sum_next != '0) begin
              state <= S_MOD;
            end else begin
              now   <= now + TIME_W'(1);
              state <= S_DONE;
            end
          end
        end
        S_MOD: begin
          if (mod_done) begin
            draw  <= mod_rem + SUM_W'(1);
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_vld) begin
            if (hit) begin
              busy[rd_idx] <= (rd_ent.remaining != REM_W'(1));
              grant_q      <= ID_W'({1'b0, rd_idx} + (SW + 1)'(1));
              fin_q        <= (rd_ent.remaining == REM_W'(1));
              now          <= now + TIME_W'(1);
              state        <= S_DONE;
            end else begin
              draw <= draw - SUM_W'(tk);
              if (rd_idx == LAST) begin
                now   <= now + TIME_W'(1);
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            granted_id   <= grant_q;
            finished     <= fin_q;
            finish_time  <= now;
            all_done     <= (busy == '0);
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_draw_lands, clk, rst, walk_last, hit)
  `ASSERT_NEXT(a_time_step, clk, rst, 1'b1, (now - $past(now)) <= TIME_W'(1))
  `ASSERT_NEXT(a_busy_src, clk, rst, busy_hold, busy == $past(busy))

endmodule
`default_nettype wire

[tb/lottery_tick_scheduler_tb.sv]
`timescale 1ns / 100ps
module lottery_tick_scheduler_tb;
  import lts_pkg::*;

  localparam int NSLOT = SLOTS_DEF;
  localparam int ITEM_TARGET = 1875;
  localparam int TAIL_ITEMS = 200;
  localparam int SETTLE_CYCLES = 2 * NSLOT + 48;

  typedef struct packed {
    logic                 kind;
    logic [SLOT_IN_W-1:0] slot;
    logic [ARR_W-1:0]     arrival;
    logic [REM_W-1:0]     work_units;
    logic [PRIO_W-1:0]    prio;
    logic [RAND_W-1:0]    random_value;
  } sched_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   granted_id;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic              all_done;
  } sched_outcome_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic                 kind = KIND_LOAD;
  logic [SLOT_IN_W-1:0] slot = '0;
  logic [ARR_W-1:0]     arrival = '0;
  logic [REM_W-1:0]     work_units = '0;
  logic [PRIO_W-1:0]    prio = '0;
  logic [RAND_W-1:0]    random_value = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [ID_W-1:0]      granted_id;
  logic                 finished;
  logic [TIME_W-1:0]    finish_time;
  logic                 all_done;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TKT_W-1:0]     cfg_data = '0;

  lottery_tick_scheduler #(.SLOTS(NSLOT)) dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // scheduler shadow state
  logic [ARR_W-1:0]  task_arrival [NSLOT];
  logic [REM_W-1:0]  task_left [NSLOT];
  logic [PRIO_W-1:0] task_prio [NSLOT];
  logic [TIME_W-1:0] sched_now;
  logic [TKT_W-1:0]  tickets_p1, tickets_p2, tickets_p3;

  sched_outcome_t expected_outcomes[$];
  int  err_count = 0;
  int  items_sent = 0;
  bit  send_idling = 1'b1;
  bit  recv_idling = 1'b1;

  function automatic logic [TKT_W-1:0] prio_tickets(input logic [PRIO_W-1:0] p);
    case (p)
      PRIO_ONE:   return tickets_p1;
      PRIO_TWO:   return tickets_p2;
      PRIO_THREE: return tickets_p3;
      default:    return '0;
    endcase
  endfunction

  function automatic bit runnable(input int i);
    return task_left[i] != '0 && TIME_W'(task_arrival[i]) <= sched_now;
  endfunction

  function automatic bit work_pending();
    for (int i = 0; i < NSLOT; i++)
      if (task_left[i] != '0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic sched_outcome_t advance_schedule(input sched_item_t it);
    sched_outcome_t o;
    logic [31:0]    pool;
    longint         draw;
    o = '0;
    if (it.kind == KIND_LOAD) begin
      if (int'(it.slot) < NSLOT) begin
        task_arrival[it.slot] = it.arrival;
        task_left[it.slot]    = it.work_units;
        task_prio[it.slot]    = it.prio;
      end
    end else if (work_pending()) begin
      pool = '0;
      for (int i = 0; i < NSLOT; i++)
        if (runnable(i)) pool += 32'(prio_tickets(task_prio[i]));
      if (pool != '0) begin
        draw = longint'(32'(it.random_value) % pool) + 1;
        for (int i = 0; i < NSLOT; i++) begin
          if (runnable(i)) begin
            draw -= longint'(prio_tickets(task_prio[i]));
            if (draw <= 0) begin
              task_left[i]--;
              o.granted_id = ID_W'(i + 1);
              o.finished   = (task_left[i] == '0);
              break;
            end
          end
        end
      end
      sched_now++;
    end
    o.finish_time = sched_now;
    o.all_done    = !work_pending();
    return o;
  endfunction

  function automatic sched_item_t load_item(input int s, input logic [ARR_W-1:0] arr,
                                            input logic [REM_W-1:0] work,
                                            input logic [PRIO_W-1:0] p);
    sched_item_t it;
    it.kind         = KIND_LOAD;
    it.slot         = SLOT_IN_W'(s);
    it.arrival      = arr;
    it.work_units   = work;
    it.prio         = p;
    it.random_value = RAND_W'($urandom());
    return it;
  endfunction

  function automatic sched_item_t tick_item(input logic [RAND_W-1:0] rv);
    sched_item_t it;
    it.kind         = KIND_TICK;
    it.slot         = SLOT_IN_W'($urandom());
    it.arrival      = ARR_W'($urandom());
    it.work_units   = REM_W'($urandom());
    it.prio         = PRIO_W'($urandom());
    it.random_value = rv;
    return it;
  endfunction

  function automatic sched_item_t noise_item();
    sched_item_t it;
    it.kind         = 1'($urandom());
    it.slot         = SLOT_IN_W'($urandom());
    it.arrival      = ARR_W'($urandom());
    it.work_units   = REM_W'($urandom());
    it.prio         = PRIO_W'($urandom());
    it.random_value = RAND_W'($urandom());
    return it;
  endfunction

  task automatic send_item(input sched_item_t it);
    int             gap;
    sched_outcome_t exp_o;
    gap = (send_idling && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    @(negedge clk);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    kind         <= it.kind;
    slot         <= it.slot;
    arrival      <= it.arrival;
    work_units   <= it.work_units;
    prio         <= it.prio;
    random_value <= it.random_value;
    item_valid   <= 1'b1;
    do @(posedge clk); while (item_stall);
    exp_o = advance_schedule(it);
    expected_outcomes.insert(expected_outcomes.size(), exp_o);
    items_sent++;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (expected_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TKT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TKT1: tickets_p1 = val;
      CFG_TKT2: tickets_p2 = val;
      CFG_TKT3: tickets_p3 = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_tickets(input logic [TKT_W-1:0] t1, input logic [TKT_W-1:0] t2,
                             input logic [TKT_W-1:0] t3);
    wait_drain();
    write_reg(CFG_TKT1, t1);
    write_reg(CFG_TKT2, t2);
    write_reg(CFG_TKT3, t3);
  endtask

  // optional noise, one batch of tasks, ticked until done or out of budget, then optional cleanup
  task automatic run_sequence();
    int                budget;
    int                n_tasks;
    logic [REM_W-1:0]  w;
    logic [PRIO_W-1:0] p;
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 4)) send_item(noise_item());
    n_tasks = $urandom_range(1, 6);
    budget = 0;
    repeat (n_tasks) begin
      w = ($urandom_range(0, 15) == 0) ? '0 : REM_W'($urandom_range(1, 8));
      p = ($urandom_range(0, 9) == 0) ? PRIO_W'(0) : PRIO_W'($urandom_range(1, 3));
      send_item(load_item($urandom_range(0, NSLOT - 1),
                          ARR_W'(sched_now + TIME_W'($urandom_range(0, 12))), w, p));
      budget += int'(w);
    end
    budget += $urandom_range(0, 16);
    for (int k = 0; k < budget && work_pending(); k++)
      send_item(tick_item(RAND_W'($urandom())));
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 2)) send_item(tick_item(RAND_W'($urandom())));
    if ($urandom_range(0, 3) != 0)
      for (int i = 0; i < NSLOT; i++)
        if (task_left[i] != '0 && $urandom_range(0, 3) != 0)
          send_item(load_item(i, ARR_W'($urandom()), '0, PRIO_W'($urandom())));
    if ($urandom_range(0, 15) == 0)
      wait_drain();
  endtask

  task automatic test_reset_state();
    send_item(tick_item(RAND_W'($urandom())));
    send_item(load_item(3, '0, '0, PRIO_ONE));
  endtask

  task automatic test_directed_cases();
    send_item(load_item(0, '0, 16'd2, PRIO_ONE));
    send_item(load_item(NSLOT - 1, '0, 16'd1, PRIO_THREE));
    send_item(load_item(7, 16'd3, 16'd1, PRIO_TWO));
    send_item(load_item(9, '0, 16'hFFFF, PRIO_W'(0)));
    send_item(tick_item('0));
    send_item(tick_item('1));
    send_item(tick_item(RAND_W'(19)));
    repeat (4) send_item(tick_item(RAND_W'($urandom())));
    // only a priority-zero task left: ticks go idle
    repeat (2) send_item(tick_item(RAND_W'($urandom())));
    send_item(load_item(9, 16'hFFFF, '0, PRIO_THREE));
    send_item(load_item(4, 16'hFFFF, 16'hFFFF, PRIO_ONE));
    send_item(tick_item('1));
    send_item(load_item(4, '0, '0, PRIO_ONE));
    send_item(load_item(12, '0, 16'd1, PRIO_TWO));
    send_item(tick_item(RAND_W'($urandom())));
    send_item(tick_item(RAND_W'($urandom())));
  endtask

  task automatic test_config_extremes();
    set_tickets('0, '0, '0);
    send_item(load_item(1, '0, 16'd2, PRIO_ONE));
    repeat (2) send_item(tick_item(RAND_W'($urandom())));
    set_tickets(8'hFF, 8'hFF, 8'hFF);
    repeat (2) send_item(tick_item('1));
    set_tickets(8'hFF, '0, 8'd1);
    send_item(load_item(2, '0, 16'd1, PRIO_TWO));
    send_item(load_item(3, '0, 16'd1, PRIO_THREE));
    send_item(load_item(5, '0, 16'd1, PRIO_ONE));
    repeat (3) send_item(tick_item('1));
    send_item(load_item(2, '0, '0, PRIO_TWO));
  endtask

  task automatic test_random_schedule();
    int phase;
    int phase_end;
    phase = 0;
    while (items_sent < ITEM_TARGET - TAIL_ITEMS) begin
      case (phase % 6)
        0: set_tickets(TKT1_RST, TKT2_RST, TKT3_RST);
        1: set_tickets(8'hFF, 8'hFF, 8'hFF);
        2: set_tickets('0, 8'hFF, 8'd1);
        3: set_tickets(8'd1, 8'd1, '0);
        4: set_tickets(8'd128, '0, 8'hFF);
        default: set_tickets(TKT_W'($urandom()), TKT_W'($urandom()), TKT_W'($urandom()));
      endcase
      send_idling = (phase % 3 != 2);
      recv_idling = (phase % 3 != 2);
      phase_end = items_sent + 250;
      while (items_sent < phase_end && items_sent < ITEM_TARGET - TAIL_ITEMS)
        run_sequence();
      phase++;
    end
  endtask

  task automatic test_quiet_tail();
    set_tickets(TKT_W'($urandom_range(1, 255)), TKT_W'($urandom()), TKT_W'($urandom()));
    send_idling = 1'b0;
    recv_idling = 1'b0;
    while (items_sent < ITEM_TARGET)
      run_sequence();
  endtask

  // result side backpressure
  initial begin
    forever begin
      @(negedge clk);
      if (recv_idling && $urandom_range(0, 7) == 0) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_results
    sched_outcome_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_outcomes.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected transaction: id %0d finished %0b time %0d all_done %0b",
                   granted_id, finished, finish_time, all_done);
      end else begin
        want = expected_outcomes.pop_front();
        if (granted_id !== want.granted_id || finished !== want.finished ||
            finish_time !== want.finish_time || all_done !== want.all_done) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch (exp/act): id %0d/%0d finished %0b/%0b time %0d/%0d done %0b/%0b",
                     want.granted_id, granted_id, want.finished, finished,
                     want.finish_time, finish_time, want.all_done, all_done);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      task_arrival[i] = '0;
      task_left[i]    = '0;
      task_prio[i]    = '0;
    end
    sched_now  = '0;
    tickets_p1 = TKT1_RST;
    tickets_p2 = TKT2_RST;
    tickets_p3 = TKT3_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_directed_cases();
    test_config_extremes();
    test_random_schedule();
    test_quiet_tail();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_outcomes.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
